FILE: hdl/lmdv_pkg.sv
// Shared constants, types and twiddle-table functions for the low-mode row DFT.
`default_nettype none

package lmdv_pkg;

  // Parameter defaults.
  localparam int ROW_LENGTH_DEF  = 128;
  localparam int MODE_COUNT_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed widths of the result fields and the twiddles.
  localparam int TW_FRAC  = 15;
  localparam int TW_BITS  = 16;
  localparam int OUT_BITS = 23;
  localparam int IDX_BITS = 3;
  localparam int ACC_W    = TW_FRAC + OUT_BITS;
  localparam int N_COMP   = 3;

  // pi in Q30 scaled so that (r * PI_Q30) >> 31 gives r * pi / 2^31.
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Taylor divisors for terms one to seven.
  localparam longint unsigned SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};
  localparam longint unsigned COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

  // Per-lane control from the top level.
  typedef struct packed {
    logic adv;        // pipeline moves this cycle
    logic take;       // a site transfer happens this cycle
    logic take_last;  // that site closes the row
    logic acc_en;     // stage two holds a site to accumulate
    logic acc_clr;    // that site closes the row
  } lmdv_ctl_t;

  // Scaled sums of one mode, one entry per component.
  typedef struct packed {
    logic [N_COMP-1:0][OUT_BITS-1:0] re;
    logic [N_COMP-1:0][OUT_BITS-1:0] im;
  } lmdv_res_t;

  function automatic logic [TW_BITS-1:0] q30_to_q15(input longint s);
    longint unsigned v;
    begin
      if (s < 0) begin
        v = 0;
      end else begin
        v = (longint'(s) + 64'd16384) >> TW_FRAC;
      end
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      return TW_BITS'(v);
    end
  endfunction

  // Returns {cos, -sin} in Q1.15 for the 32-bit phase p (full turn = 2^32).
  function automatic logic [2*TW_BITS-1:0] tw_entry(input logic [31:0] p);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint ss;
    longint sc;
    int s;
    int c;
    int sn;
    int cs;
    begin
      r  = longint'(p[29:0]);
      x  = (r * PI_Q30) >> 31;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      sc = longint'(64'd1 << 30);
      for (int k = 1; k <= 7; k++) begin
        ts = ((ts * x2) >> 30) / SIN_DIV[k-1];
        tc = ((tc * x2) >> 30) / COS_DIV[k-1];
        if (k % 2 == 1) begin
          ss = ss - longint'(ts);
          sc = sc - longint'(tc);
        end else begin
          ss = ss + longint'(ts);
          sc = sc + longint'(tc);
        end
      end
      s = int'(q30_to_q15(ss));
      c = int'(q30_to_q15(sc));
      unique case (p[31:30])
        2'd0: begin sn = s;  cs = c;  end
        2'd1: begin sn = c;  cs = -s; end
        2'd2: begin sn = -s; cs = -c; end
        default: begin sn = -c; cs = s; end
      endcase
      return {TW_BITS'(cs), TW_BITS'(-sn)};
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lmdv_if.sv
// Valid/ready channel interfaces for site inputs and mode results.
`default_nettype none

interface lmdv_site_if
  import lmdv_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] comp_x;
  logic signed [SAMPLE_BITS-1:0] comp_y;
  logic signed [SAMPLE_BITS-1:0] comp_z;
  logic                          last_site;

  modport source (output valid, comp_x, comp_y, comp_z, last_site, input ready);
  modport sink   (input valid, comp_x, comp_y, comp_z, last_site, output ready);
endinterface

interface lmdv_mode_if
  import lmdv_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic        [IDX_BITS-1:0] mode_index;
  logic signed [OUT_BITS-1:0] re_x;
  logic signed [OUT_BITS-1:0] re_y;
  logic signed [OUT_BITS-1:0] re_z;
  logic signed [OUT_BITS-1:0] im_x;
  logic signed [OUT_BITS-1:0] im_y;
  logic signed [OUT_BITS-1:0] im_z;
  logic                       last_mode;

  modport source (output valid, mode_index, re_x, re_y, re_z, im_x, im_y, im_z,
                  last_mode, input ready);
  modport sink   (input valid, mode_index, re_x, re_y, re_z, im_x, im_y, im_z,
                  last_mode, output ready);
endinterface

`default_nettype wire

FILE: hdl/lmdv_lane.sv
// One mode lane: phase tracking, twiddle lookup, products and accumulators.
`default_nettype none

module lmdv_lane
  import lmdv_pkg::*;
#(
  parameter int ROW_LENGTH  = ROW_LENGTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int MODE        = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lmdv_ctl_t                     ctl,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_x,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_y,
  input  wire logic signed [SAMPLE_BITS-1:0] smp_z,
  output lmdv_res_t                          sums
);

  localparam int PH_W   = $clog2(ROW_LENGTH);
  localparam int STEP   = MODE % ROW_LENGTH;
  localparam int PROD_W = SAMPLE_BITS + TW_BITS;

  logic [2*TW_BITS-1:0] rom [ROW_LENGTH];

  for (genvar a = 0; a < ROW_LENGTH; a++) begin : g_rom
    localparam longint unsigned PHASE = (longint'(a) << 32) / ROW_LENGTH;
    localparam logic [2*TW_BITS-1:0] ENTRY = tw_entry(PHASE[31:0]);
    assign rom[a] = ENTRY;
  end

  logic        [PH_W-1:0]    phase;
  logic        [PH_W:0]      ph_sum;
  logic        [PH_W-1:0]    phase_next;
  logic signed [TW_BITS-1:0] tw_cos;
  logic signed [TW_BITS-1:0] tw_nsin;
  logic signed [SAMPLE_BITS-1:0] smp [N_COMP];
  logic signed [PROD_W-1:0]  prod_re [N_COMP];
  logic signed [PROD_W-1:0]  prod_im [N_COMP];
  logic        [ACC_W-1:0]   acc_re  [N_COMP];
  logic        [ACC_W-1:0]   acc_im  [N_COMP];
  logic        [ACC_W-1:0]   sum_re  [N_COMP];
  logic        [ACC_W-1:0]   sum_im  [N_COMP];

  assign smp[0] = smp_x;
  assign smp[1] = smp_y;
  assign smp[2] = smp_z;

  // The table index for site x is x*MODE mod ROW_LENGTH, stepped by MODE per site.
  always_comb begin
    ph_sum = {1'b0, phase} + (PH_W+1)'(STEP);
    if (ph_sum >= (PH_W+1)'(ROW_LENGTH)) begin
      phase_next = PH_W'(ph_sum - (PH_W+1)'(ROW_LENGTH));
    end else begin
      phase_next = ph_sum[PH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (ctl.take) begin
      phase <= ctl.take_last ? '0 : phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      tw_cos  <= rom[phase][2*TW_BITS-1:TW_BITS];
      tw_nsin <= rom[phase][TW_BITS-1:0];
      for (int c = 0; c < N_COMP; c++) begin
        prod_re[c] <= smp[c] * tw_cos;
        prod_im[c] <= smp[c] * tw_nsin;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < N_COMP; c++) begin
      sum_re[c] = acc_re[c] + ACC_W'(prod_re[c]);
      sum_im[c] = acc_im[c] + ACC_W'(prod_im[c]);
      sums.re[c] = sum_re[c][ACC_W-1:TW_FRAC];
      sums.im[c] = sum_im[c][ACC_W-1:TW_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < N_COMP; c++) begin
        acc_re[c] <= '0;
        acc_im[c] <= '0;
      end
    end else if (ctl.acc_en) begin
      for (int c = 0; c < N_COMP; c++) begin
        acc_re[c] <= ctl.acc_clr ? '0 : sum_re[c];
        acc_im[c] <= ctl.acc_clr ? '0 : sum_im[c];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lmdv_merge.sv
// Result bank that captures all lane sums at row end and sends them mode by mode.
`default_nettype none

module lmdv_merge
  import lmdv_pkg::*;
#(
  parameter int MODE_COUNT = MODE_COUNT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire lmdv_res_t sums [MODE_COUNT],
  output logic           free,
  lmdv_mode_if.source    mode
);

  localparam int SEL_W = (MODE_COUNT > 1) ? $clog2(MODE_COUNT) : 1;
  localparam logic [SEL_W-1:0] SEL_LAST = SEL_W'(MODE_COUNT - 1);

  lmdv_res_t        bank [MODE_COUNT];
  logic [SEL_W-1:0] sel;
  logic             busy;
  logic             done;

  assign done = busy && mode.ready && (sel == SEL_LAST);
  assign free = !busy || done;

  always_ff @(posedge clk) begin
    if (load) begin
      bank <= sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      sel  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      sel  <= '0;
    end else if (busy && mode.ready) begin
      if (sel == SEL_LAST) begin
        busy <= 1'b0;
      end else begin
        sel <= sel + 1'b1;
      end
    end
  end

  assign mode.valid      = busy;
  assign mode.mode_index = IDX_BITS'(sel);
  assign mode.re_x       = bank[sel].re[0];
  assign mode.re_y       = bank[sel].re[1];
  assign mode.re_z       = bank[sel].re[2];
  assign mode.im_x       = bank[sel].im[0];
  assign mode.im_y       = bank[sel].im[1];
  assign mode.im_z       = bank[sel].im[2];
  assign mode.last_mode  = (sel == SEL_LAST);

endmodule

`default_nettype wire

FILE: hdl/low_mode_dft_vector_row_top.sv
// Top level of the low-mode partial DFT over one row of three-component spins.
//
// The site channel carries one lattice site per transfer: comp_x, comp_y and
// comp_z as signed Q1.15 samples and last_site, which closes the row. Each of
// the MODE_COUNT lanes keeps real and imaginary sums for its mode and all three
// components, and every lane updates on every site, so one site is accepted per
// cycle while the pipeline is not held. The row length sets the twiddle table
// that each lane reads. A site passes through a twiddle/sample register, a
// product register and the accumulators. When the closing site reaches the
// accumulators, all lane sums are copied into the result bank and the sums
// clear for the next row. The mode channel then offers one result per mode,
// lowest mode first, one per cycle while the receiver takes them, with
// last_mode on the highest. New sites keep flowing while results drain; only a
// closing site that finds the bank still draining waits in the product stage,
// which holds the pipeline and drops ready on the site channel. Rows of at
// least MODE_COUNT sites therefore run at full rate with a receiver that never
// stalls. A stalled receiver simply holds the current result.
// Reset clears the site position, the sums and the result bank state.
`default_nettype none

module low_mode_dft_vector_row_top
  import lmdv_pkg::*;
#(
  parameter int ROW_LENGTH  = ROW_LENGTH_DEF,
  parameter int MODE_COUNT  = MODE_COUNT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  lmdv_site_if.sink   site,
  lmdv_mode_if.source mode
);

  logic                          adv;
  logic                          free;
  logic                          load;
  logic                          s1_valid;
  logic                          s1_last;
  logic                          s2_valid;
  logic                          s2_last;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic signed [SAMPLE_BITS-1:0] s1_y;
  logic signed [SAMPLE_BITS-1:0] s1_z;
  lmdv_ctl_t                     ctl;
  lmdv_res_t                     sums [MODE_COUNT];

  // The whole pipeline holds only while a closing site waits for the bank.
  assign adv  = !(s2_valid && s2_last && !free);
  assign load = adv && s2_valid && s2_last;
  assign site.ready = adv;

  assign ctl.adv       = adv;
  assign ctl.take      = adv && site.valid;
  assign ctl.take_last = site.last_site;
  assign ctl.acc_en    = adv && s2_valid;
  assign ctl.acc_clr   = s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= site.valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x    <= site.comp_x;
      s1_y    <= site.comp_y;
      s1_z    <= site.comp_z;
      s1_last <= site.last_site;
      s2_last <= s1_last;
    end
  end

  for (genvar m = 0; m < MODE_COUNT; m++) begin : g_lane
    lmdv_lane #(
      .ROW_LENGTH (ROW_LENGTH),
      .SAMPLE_BITS(SAMPLE_BITS),
      .MODE       (m)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .smp_x(s1_x),
      .smp_y(s1_y),
      .smp_z(s1_z),
      .sums (sums[m])
    );
  end

  lmdv_merge #(
    .MODE_COUNT(MODE_COUNT)
  ) u_merge (
    .clk (clk),
    .rst (rst),
    .load(load),
    .sums(sums),
    .free(free),
    .mode(mode)
  );

endmodule

`default_nettype wire
